// File: rtl/core/rcn_pkg.sv
// Shared types and constants for the normalised 3x3 RGB filter.
// Used by rcn_kernel_unit and rgb_conv3x3_normalized; depends on nothing.
`default_nettype none

package rcn_pkg;

  localparam int unsigned PIX_W  = 24;  // packed RGB word, red in the low byte
  localparam int unsigned WGT_W  = 48;  // three Q8.8 weights per column register
  localparam int unsigned GEOM_W = 11;  // width and height registers
  localparam int unsigned ACC_W  = 28;  // signed channel sum over nine taps
  localparam int unsigned KS_W   = 20;  // signed weight sum over nine taps
  localparam int unsigned DIV_W  = 19;  // positive divisor after the non-positive fix-up

  localparam logic [WGT_W-1:0] WGT_RESET = 48'h00C0_00C0_00C0;
  localparam logic [GEOM_W-1:0] GEOM_RESET = 11'd1024;

  localparam logic [2:0] CFG_W_LEFT   = 3'd0;
  localparam logic [2:0] CFG_W_CENTRE = 3'd1;
  localparam logic [2:0] CFG_W_RIGHT  = 3'd2;
  localparam logic [2:0] CFG_WIDTH    = 3'd3;
  localparam logic [2:0] CFG_HEIGHT   = 3'd4;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [2:0][2:0][PIX_W-1:0] win_t;  // [row][column]
  typedef logic [2:0][WGT_W-1:0] wts_t;       // [column]

  typedef struct packed {
    logic       start;
    logic [2:0] row_ok;
    logic [2:0] col_ok;
  } kern_req_t;

  typedef struct packed {
    logic done;
    pix_t rgb;
  } kern_rsp_t;

endpackage

`default_nettype wire

// File: rtl/core/rcn_kernel_unit.sv
// Nine-tap multiply-accumulate and saturating 8-bit divider for one result.
// Depends on rcn_pkg.
`default_nettype none

module rcn_kernel_unit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rcn_pkg::kern_req_t req_i,
  input  wire rcn_pkg::win_t     win_i,
  input  wire rcn_pkg::wts_t     wts_i,
  output rcn_pkg::kern_rsp_t     rsp_o
);

  typedef enum logic [4:0] {
    K_IDLE = 5'b00001,
    K_MAC  = 5'b00010,
    K_SAT  = 5'b00100,
    K_DIV  = 5'b01000,
    K_DONE = 5'b10000
  } kst_e;

  kst_e kst_q;
  logic [1:0] tr_q, tc_q;
  logic [2:0] bit_q;
  logic [2:0] row_ok_q, col_ok_q;
  logic signed [rcn_pkg::ACC_W-1:0] acc_q [3];
  logic signed [rcn_pkg::KS_W-1:0]  ksum_q;
  logic [rcn_pkg::DIV_W-1:0]        div_q;
  logic [rcn_pkg::ACC_W-2:0]        rem_q [3];
  logic [7:0]                       quo_q [3];
  logic [2:0]                       zero_q, max_q;

  logic signed [15:0] wt;
  logic               tap_ok;
  logic signed [rcn_pkg::KS_W-1:0] ks_fix;
  logic [rcn_pkg::ACC_W-1:0]       lim;
  logic [rcn_pkg::ACC_W-2:0]       trial;

  always_comb begin
    wt     = $signed(wts_i[tc_q][{tr_q, 4'b0000} +: 16]);
    tap_ok = row_ok_q[tr_q] && col_ok_q[tc_q];
    ks_fix = (ksum_q <= 0) ? rcn_pkg::KS_W'(256) : ksum_q;
    lim    = rcn_pkg::ACC_W'($unsigned(ks_fix)) << 8;
    trial  = (rcn_pkg::ACC_W-1)'(div_q) << bit_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kst_q <= K_IDLE;
      tr_q  <= '0;
      tc_q  <= '0;
      bit_q <= '0;
    end else begin
      unique case (kst_q)
        K_IDLE: if (req_i.start) begin
          kst_q <= K_MAC;
          tr_q  <= '0;
          tc_q  <= '0;
        end
        K_MAC: begin
          if (tc_q == 2'd2) begin
            tc_q <= '0;
            if (tr_q == 2'd2) kst_q <= K_SAT;
            else tr_q <= tr_q + 2'd1;
          end else begin
            tc_q <= tc_q + 2'd1;
          end
        end
        K_SAT: begin
          bit_q <= 3'd7;
          kst_q <= K_DIV;
        end
        K_DIV: begin
          if (bit_q == 3'd0) kst_q <= K_DONE;
          else bit_q <= bit_q - 3'd1;
        end
        K_DONE: kst_q <= K_IDLE;
        default: kst_q <= K_IDLE;
      endcase
    end
  end

  // Datapath: clear on start, accumulate, then restoring division one bit a cycle.
  always_ff @(posedge clk_i) begin
    if (kst_q == K_IDLE && req_i.start) begin
      row_ok_q <= req_i.row_ok;
      col_ok_q <= req_i.col_ok;
      ksum_q   <= '0;
      for (int ch = 0; ch < 3; ch++) acc_q[ch] <= '0;
    end
    if (kst_q == K_MAC && tap_ok) begin
      ksum_q <= ksum_q + rcn_pkg::KS_W'(wt);
      for (int ch = 0; ch < 3; ch++) begin
        acc_q[ch] <= acc_q[ch] + rcn_pkg::ACC_W'(
          $signed({1'b0, win_i[tr_q][tc_q][8*ch +: 8]}) * wt);
      end
    end
    if (kst_q == K_SAT) begin
      div_q <= rcn_pkg::DIV_W'($unsigned(ks_fix));
      for (int ch = 0; ch < 3; ch++) begin
        zero_q[ch] <= acc_q[ch][rcn_pkg::ACC_W-1];
        max_q[ch]  <= !acc_q[ch][rcn_pkg::ACC_W-1] && ($unsigned(acc_q[ch]) >= lim);
        rem_q[ch]  <= acc_q[ch][rcn_pkg::ACC_W-2:0];
        quo_q[ch]  <= '0;
      end
    end
    if (kst_q == K_DIV) begin
      for (int ch = 0; ch < 3; ch++) begin
        if (rem_q[ch] >= trial) begin
          rem_q[ch]        <= rem_q[ch] - trial;
          quo_q[ch][bit_q] <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    rsp_o.done = (kst_q == K_DONE);
    for (int ch = 0; ch < 3; ch++) begin
      rsp_o.rgb[8*ch +: 8] = zero_q[ch] ? 8'd0 : (max_q[ch] ? 8'd255 : quo_q[ch]);
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/rgb_conv3x3_normalized.sv
// Top level of the normalised 3x3 RGB filter: line store, window, sequencer.
// Depends on rcn_pkg and rcn_kernel_unit.
`default_nettype none

// Raster-order RGB words enter on the slave stream (tuser high marks a flush
// tick) and leave as filtered words W+1 positions behind. The two previous
// rows sit in one 48-bit-wide simple dual-port line store with a registered
// read; each pixel does a read, a window shift and a write-back to
// the same column, with forwarding for the one-pixel-wide case where the next
// read hits the column just written. A pixel that yields no result goes back
// to idle after its read; a word that yields a result then runs the shared
// kernel unit (nine multiply-accumulate steps, one saturation check, eight
// divider steps, hand-over) and waits for a free output register, and a
// flush tick that yields a result first does one line-store read per
// virtual pixel it pushes (at most four). No word is taken while a result
// is being worked out; the next is accepted while a finished result waits
// in the output register. There is no clearing pass: taps that would read
// unwritten columns are masked. Write configuration only while the block is
// idle; a width or height write abandons the current image.
module rgb_conv3x3_normalized #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // slave stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // pixel_red, pixel_green, pixel_blue
  input  wire logic        s_axis_tuser,  // req_type
  // master stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // filtered_red, filtered_green, filtered_blue
  output logic             m_axis_tlast,  // frame_last
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [47:0] cfg_data_i
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 8);
  localparam int unsigned DW = $clog2(MAX_WIDTH + 3) + 1;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_PROD = 5'b00100,
    ST_WAIT = 5'b01000,
    ST_EMIT = 5'b10000
  } st_e;

  st_e state_q, state_d;
  rcn_pkg::wts_t wts_q;
  logic [rcn_pkg::GEOM_W-1:0] width_q, height_q;
  logic [CW-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [RW-1:0] in_row_q, in_row_d;
  logic [HW-1:0] out_row_q, out_row_d;
  logic [DW-1:0] pend_q, pend_d, diff_q, diff_d;
  logic [2:0]    guard_q, guard_d;
  logic          flush_q, flush_d;
  rcn_pkg::pix_t pix_q, pix_d;
  rcn_pkg::win_t win_q, win_d;
  logic          last_q, last_d;
  logic          out_valid_q, out_valid_d;
  rcn_pkg::pix_t out_rgb_q;
  logic          out_last_q;

  // line store: [47:24] two rows back, [23:0] one row back
  logic [2*rcn_pkg::PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*rcn_pkg::PIX_W-1:0] rdata_q, fwd_data_q, line_word, mem_wdata;
  logic                        fwd_q;
  logic                        rd_en, mem_we;
  logic [CW-1:0]               rd_addr;

  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [DW-1:0] tgt;
  logic          in_wrap, out_wrap, load_out, geom_wr;
  logic [CW-1:0] col_nx;
  logic [RW-1:0] row_nx;
  logic [DW-1:0] diff_nx;
  logic [2:0]    guard_nx;
  rcn_pkg::pix_t pix_in;
  rcn_pkg::kern_req_t kreq;
  rcn_pkg::kern_rsp_t krsp;

  // Out-of-range geometry folds to 1 or to the maximum.
  always_comb begin
    if (width_q == '0) w_eff = WW'(1);
    else if (32'(width_q) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(width_q);
    if (height_q == '0) h_eff = HW'(1);
    else if (32'(height_q) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
    else h_eff = HW'(height_q);
    tgt = DW'(w_eff) + DW'(2);
  end

  always_comb begin
    in_wrap  = (32'(in_col_q) + 32'd1) >= 32'(w_eff);
    col_nx   = in_wrap ? '0 : in_col_q + CW'(1);
    row_nx   = in_wrap ? in_row_q + RW'(1) : in_row_q;
    out_wrap = (32'(out_col_q) + 32'd1) >= 32'(w_eff);
    diff_nx  = diff_q + DW'(1);
    guard_nx = guard_q + 3'd1;
    line_word = fwd_q ? fwd_data_q : rdata_q;
    pix_in   = flush_q ? '0 : pix_q;
    geom_wr  = cfg_we_i && (cfg_idx_i == rcn_pkg::CFG_WIDTH ||
                            cfg_idx_i == rcn_pkg::CFG_HEIGHT);
  end

  assign s_axis_tready = (state_q == ST_IDLE);

  always_comb begin
    state_d   = state_q;
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    pend_d    = pend_q;
    diff_d    = diff_q;
    guard_d   = guard_q;
    flush_d   = flush_q;
    pix_d     = pix_q;
    win_d     = win_q;
    last_d    = last_q;
    rd_en     = 1'b0;
    rd_addr   = in_col_q;
    mem_we    = 1'b0;
    mem_wdata = {line_word[rcn_pkg::PIX_W-1:0], pix_in};
    load_out  = 1'b0;
    kreq      = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (!s_axis_tuser) begin
            pix_d   = s_axis_tdata;
            flush_d = 1'b0;
            rd_en   = 1'b1;
            state_d = ST_READ;
            // image complete: start a new one, drop what is still pending
            if (32'(in_row_q) >= 32'(h_eff)) begin
              in_col_d  = '0;
              in_row_d  = '0;
              out_col_d = '0;
              out_row_d = '0;
              pend_d    = '0;
              diff_d    = '0;
              rd_addr   = '0;
            end
          end else if (32'(in_row_q) >= 32'(h_eff) && pend_q != '0) begin
            flush_d = 1'b1;
            guard_d = '0;
            if (diff_q < tgt) begin
              rd_en   = 1'b1;
              state_d = ST_READ;
            end else begin
              state_d = ST_PROD;
            end
          end
        end
      end
      ST_READ: begin
        // shift the window, write the column back, advance the input position
        for (int r = 0; r < 3; r++) begin
          win_d[r][0] = win_q[r][1];
          win_d[r][1] = win_q[r][2];
        end
        win_d[0][2] = line_word[2*rcn_pkg::PIX_W-1:rcn_pkg::PIX_W];
        win_d[1][2] = line_word[rcn_pkg::PIX_W-1:0];
        win_d[2][2] = pix_in;
        mem_we   = 1'b1;
        in_col_d = col_nx;
        in_row_d = row_nx;
        diff_d   = diff_nx;
        if (!flush_q) begin
          pend_d  = pend_q + DW'(1);
          state_d = (diff_nx == tgt) ? ST_PROD : ST_IDLE;
        end else begin
          guard_d = guard_nx;
          if (guard_nx < 3'd4 && diff_nx < tgt) begin
            rd_en   = 1'b1;
            rd_addr = col_nx;
          end else begin
            state_d = ST_PROD;
          end
        end
      end
      ST_PROD: begin
        kreq.start  = 1'b1;
        kreq.row_ok = {(32'(out_row_q) + 32'd1) < 32'(h_eff), 1'b1, out_row_q != '0};
        kreq.col_ok = {out_wrap == 1'b0, 1'b1, out_col_q != '0};
        last_d = (32'(out_row_q) + 32'd1 == 32'(h_eff)) && out_wrap;
        if (out_wrap) begin
          out_col_d = '0;
          out_row_d = out_row_q + HW'(1);
        end else begin
          out_col_d = out_col_q + CW'(1);
        end
        if (pend_q != '0) pend_d = pend_q - DW'(1);
        diff_d  = diff_q - DW'(1);
        state_d = ST_WAIT;
      end
      ST_WAIT: if (krsp.done) state_d = ST_EMIT;
      ST_EMIT: begin
        if (!out_valid_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (geom_wr) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
      pend_d    = '0;
      diff_d    = '0;
    end
  end

  always_comb begin
    if (load_out) out_valid_d = 1'b1;
    else if (m_axis_tready) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wts_q       <= {3{rcn_pkg::WGT_RESET}};
      width_q     <= rcn_pkg::GEOM_RESET;
      height_q    <= rcn_pkg::GEOM_RESET;
      in_col_q    <= '0;
      in_row_q    <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      pend_q      <= '0;
      diff_q      <= '0;
      guard_q     <= '0;
      flush_q     <= 1'b0;
      win_q       <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
      fwd_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_col_q    <= in_col_d;
      in_row_q    <= in_row_d;
      out_col_q   <= out_col_d;
      out_row_q   <= out_row_d;
      pend_q      <= pend_d;
      diff_q      <= diff_d;
      guard_q     <= guard_d;
      flush_q     <= flush_d;
      win_q       <= win_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
      fwd_q       <= rd_en && mem_we && (rd_addr == in_col_q);
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          rcn_pkg::CFG_W_LEFT:   wts_q[0] <= cfg_data_i;
          rcn_pkg::CFG_W_CENTRE: wts_q[1] <= cfg_data_i;
          rcn_pkg::CFG_W_RIGHT:  wts_q[2] <= cfg_data_i;
          rcn_pkg::CFG_WIDTH:    width_q  <= cfg_data_i[rcn_pkg::GEOM_W-1:0];
          rcn_pkg::CFG_HEIGHT:   height_q <= cfg_data_i[rcn_pkg::GEOM_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pix_q      <= pix_d;
    fwd_data_q <= mem_wdata;
    if (load_out) begin
      out_rgb_q  <= krsp.rgb;
      out_last_q <= last_q;
    end
  end

  // line store
  always_ff @(posedge clk_i) begin
    if (mem_we) line_mem[in_col_q] <= mem_wdata;
    if (rd_en) rdata_q <= line_mem[rd_addr];
  end

  rcn_kernel_unit u_kernel (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (kreq),
    .win_i  (win_q),
    .wts_i  (wts_q),
    .rsp_o  (krsp)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_rgb_q;
  assign m_axis_tlast  = out_last_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("sequencer state not one-hot");

  a_diff_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    diff_q <= tgt) else $error("input runs more than a row and two ahead");

  a_pend_le_diff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= diff_q) else $error("pending count above position gap");

  a_fwd_narrow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> (w_eff == WW'(1))) else $error("forwarding outside one-pixel rows");

  a_emit_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WAIT && krsp.done) |=> (state_q == ST_EMIT))
    else $error("kernel result not taken");

endmodule

`default_nettype wire
